// ===== hdl/mtv_pkg.sv =====
// mtv_pkg: shared constants, character codes, stack control type and cdata character
// lookup for the markup tag validator; no dependencies
`default_nettype none

package mtv_pkg;

	// default sizes for the top level parameters
	localparam int STACK_DEPTH_DEF  = 256;
	localparam int NAME_MAX_LEN_DEF = 9;

	// bits per packed name letter ('A' = 1 .. 'Z' = 26)
	localparam int LETTER_W = 5;

	// ascii codes the parser looks for
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_T     = 8'h54;

	// length of "[CDATA[" after "<!"
	localparam logic [2:0] CD_LEN = 3'd7;

	// shift command for the row of stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} stack_op_t;

	// expected character at each place of "[CDATA["
	function automatic logic [7:0] cd_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = CH_LBRK;
			3'd1: ch = CH_C;
			3'd2: ch = CH_D;
			3'd3: ch = CH_A;
			3'd4: ch = CH_T;
			3'd5: ch = CH_A;
			3'd6: ch = CH_LBRK;
			default: ch = CH_LBRK;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/markup_tag_validator.sv =====
// markup_tag_validator: takes one text word per cycle, back to back, while in_ready is high.
// the verdict is registered from the last word into the output register, or into the skid entry if that is held.
// the open-tag stack is a row of cells that all shift together on a push or pop.
// a two-entry output buffer keeps input flowing while a verdict waits; in_ready drops when both are full.
// reset: arst_n clears the parse state, stack count and output buffer at once;
// stack cells hold no reset value and are only read below the count.
`default_nettype none

module markup_tag_validator #(
	parameter int STACK_DEPTH  = mtv_pkg::STACK_DEPTH_DEF,
	parameter int NAME_MAX_LEN = mtv_pkg::NAME_MAX_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            text_valid
);

	localparam int LETTERS_W = mtv_pkg::LETTER_W * NAME_MAX_LEN;
	localparam int LEN_W     = $clog2(NAME_MAX_LEN + 1);
	localparam int ENTRY_W   = LETTERS_W + LEN_W;

	logic               accept;
	mtv_pkg::stack_op_t op;
	logic [ENTRY_W-1:0] push_entry;
	logic               result;
	logic [ENTRY_W-1:0] cell_data [STACK_DEPTH];

	logic out_valid_q, out_data_q;
	logic skid_valid_q, skid_data_q;
	logic res_push, res_pop;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	// parse control
	mtv_parser #(
		.STACK_DEPTH (STACK_DEPTH),
		.NAME_MAX_LEN(NAME_MAX_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.last_byte (last_byte),
		.top_entry (cell_data[0]),
		.op        (op),
		.push_entry(push_entry),
		.result    (result)
	);

	// open-tag stack, top entry in cell zero
	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [ENTRY_W-1:0] prev_w, next_w;
		if (g == 0) begin : g_head
			assign prev_w = push_entry;
		end else begin : g_mid
			assign prev_w = cell_data[g-1];
		end
		if (g == STACK_DEPTH - 1) begin : g_tail
			assign next_w = cell_data[g];
		end else begin : g_body
			assign next_w = cell_data[g+1];
		end
		mtv_cell #(
			.W(ENTRY_W)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.prev_data(prev_w),
			.next_data(next_w),
			.data     (cell_data[g])
		);
	end

	// verdict buffer: output register plus skid entry
	assign res_push = accept && last_byte;
	assign res_pop  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res_pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_push;
			end else begin
				out_valid_q <= res_push;
			end
		end else if (res_push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res_pop) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= result;
			end else begin
				out_data_q <= result;
			end
		end else if (res_push) begin
			skid_data_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/mtv_cell.sv =====
// mtv_cell: one entry of the shifting tag stack
// depends on mtv_pkg (stack_op_t)
`default_nettype none

module mtv_cell #(
	parameter int W = 49
) (
	input  wire logic              clk,
	input  wire mtv_pkg::stack_op_t op,
	input  wire logic [W-1:0]      prev_data,
	input  wire logic [W-1:0]      next_data,
	output logic      [W-1:0]      data
);

	logic [W-1:0] data_q;

	// push moves entries away from the top, pop moves them toward it
	always_ff @(posedge clk) begin
		if (op.push) begin
			data_q <= prev_data;
		end else if (op.pop) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== hdl/mtv_parser.sv =====
// mtv_parser: per-word parse state machine, name capture and stack count
// depends on mtv_pkg (character codes, cd_char, stack_op_t)
`default_nettype none

module mtv_parser #(
	parameter int STACK_DEPTH  = mtv_pkg::STACK_DEPTH_DEF,
	parameter int NAME_MAX_LEN = mtv_pkg::NAME_MAX_LEN_DEF,
	localparam int LETTERS_W   = mtv_pkg::LETTER_W * NAME_MAX_LEN,
	localparam int LEN_W       = $clog2(NAME_MAX_LEN + 1),
	localparam int ENTRY_W     = LETTERS_W + LEN_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         text_byte,
	input  wire logic               last_byte,
	input  wire logic [ENTRY_W-1:0] top_entry,
	output mtv_pkg::stack_op_t      op,
	output logic      [ENTRY_W-1:0] push_entry,
	output logic                    result
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		M_START,
		M_CONTENT,
		M_LT,
		M_CD_PREFIX,
		M_CD_BODY,
		M_OPEN_NAME,
		M_CLOSE_NAME,
		M_DONE,
		M_ERROR
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [2:0]           idx_q, idx_d;
	logic [1:0]           run_q, run_d;
	logic [LETTERS_W-1:0] letters_q, letters_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 root_q, root_d;
	mtv_pkg::stack_op_t   op_raw;

	logic                         is_upper;
	logic [7:0]                   letter_v;
	logic [mtv_pkg::LETTER_W-1:0] letter_code;
	logic                         name_full;
	logic [LETTERS_W-1:0]         appended;
	logic [LETTERS_W-1:0]         top_letters;
	logic [LEN_W-1:0]             top_len;

	// letter decode and name append
	assign is_upper    = (text_byte >= mtv_pkg::CH_A) && (text_byte <= mtv_pkg::CH_Z);
	assign letter_v    = text_byte - mtv_pkg::CH_A + 8'd1;
	assign letter_code = letter_v[mtv_pkg::LETTER_W-1:0];
	assign name_full   = (len_q >= LEN_W'(NAME_MAX_LEN));
	assign appended    = (letters_q << mtv_pkg::LETTER_W) | LETTERS_W'(letter_code);
	assign top_letters = top_entry[ENTRY_W-1:LEN_W];
	assign top_len     = top_entry[LEN_W-1:0];

	// next state for one word
	always_comb begin
		mode_d    = mode_q;
		idx_d     = idx_q;
		run_d     = run_q;
		letters_d = letters_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		root_d    = root_q;
		op_raw    = '0;
		unique case (mode_q)
			M_START: begin
				if (text_byte == mtv_pkg::CH_LT) mode_d = M_LT;
				else mode_d = M_ERROR;
			end
			M_CONTENT: begin
				if (text_byte == mtv_pkg::CH_LT) mode_d = M_LT;
			end
			M_LT: begin
				if (text_byte == mtv_pkg::CH_BANG) begin
					if (cnt_q == '0) begin
						mode_d = M_ERROR;
					end else begin
						idx_d  = '0;
						mode_d = M_CD_PREFIX;
					end
				end else if (text_byte == mtv_pkg::CH_SLASH) begin
					letters_d = '0;
					len_d     = '0;
					mode_d    = M_CLOSE_NAME;
				end else if (is_upper) begin
					if (cnt_q == '0 && root_q) begin
						mode_d = M_ERROR;
					end else begin
						letters_d = LETTERS_W'(letter_code);
						len_d     = LEN_W'(1);
						mode_d    = M_OPEN_NAME;
					end
				end else begin
					mode_d = M_ERROR;
				end
			end
			M_CD_PREFIX: begin
				if (text_byte == mtv_pkg::cd_char(idx_q)) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == mtv_pkg::CD_LEN - 3'd1) begin
						run_d  = '0;
						mode_d = M_CD_BODY;
					end
				end else begin
					mode_d = M_ERROR;
				end
			end
			M_CD_BODY: begin
				if (text_byte == mtv_pkg::CH_RBRK) begin
					if (run_q != 2'd2) run_d = run_q + 2'd1;
				end else if (text_byte == mtv_pkg::CH_GT && run_q == 2'd2) begin
					run_d  = '0;
					mode_d = M_CONTENT;
				end else begin
					run_d = '0;
				end
			end
			M_OPEN_NAME: begin
				if (is_upper) begin
					if (name_full) begin
						mode_d = M_ERROR;
					end else begin
						letters_d = appended;
						len_d     = len_q + LEN_W'(1);
					end
				end else if (text_byte == mtv_pkg::CH_GT && len_q != '0) begin
					if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
						mode_d = M_ERROR;
					end else begin
						op_raw.push = 1'b1;
						cnt_d       = cnt_q + CNT_W'(1);
						root_d      = 1'b1;
						mode_d      = M_CONTENT;
					end
				end else begin
					mode_d = M_ERROR;
				end
			end
			M_CLOSE_NAME: begin
				if (is_upper) begin
					if (name_full) begin
						mode_d = M_ERROR;
					end else begin
						letters_d = appended;
						len_d     = len_q + LEN_W'(1);
					end
				end else if (text_byte == mtv_pkg::CH_GT && len_q != '0 && cnt_q != '0 &&
						top_letters == letters_q && top_len == len_q) begin
					op_raw.pop = 1'b1;
					cnt_d      = cnt_q - CNT_W'(1);
					mode_d     = (cnt_q == CNT_W'(1)) ? M_DONE : M_CONTENT;
				end else begin
					mode_d = M_ERROR;
				end
			end
			M_DONE: mode_d = M_ERROR;
			M_ERROR: mode_d = M_ERROR;
			default: mode_d = M_ERROR;
		endcase
	end

	// stack command and verdict for the accepted word
	assign op.push    = accept & op_raw.push;
	assign op.pop     = accept & op_raw.pop;
	assign push_entry = {letters_q, len_q};
	assign result     = (mode_d == M_DONE) && root_d && (cnt_d == '0);

	// parse state; the last word of a text returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_START;
			idx_q     <= '0;
			run_q     <= '0;
			letters_q <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			root_q    <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				mode_q    <= M_START;
				idx_q     <= '0;
				run_q     <= '0;
				letters_q <= '0;
				len_q     <= '0;
				cnt_q     <= '0;
				root_q    <= 1'b0;
			end else begin
				mode_q    <= mode_d;
				idx_q     <= idx_d;
				run_q     <= run_d;
				letters_q <= letters_d;
				len_q     <= len_d;
				cnt_q     <= cnt_d;
				root_q    <= root_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.push && op.pop))
		else $error("stack push and pop in the same cycle");

	a_no_overflow_push: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |-> cnt_q < CNT_W'(STACK_DEPTH))
		else $error("push into a full stack");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> cnt_q != '0)
		else $error("pop from an empty stack");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(op.push && !last_byte) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("stack count did not follow a push");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_DONE) |-> (cnt_q == '0 && root_q))
		else $error("root closed with open tags left");
`endif

endmodule

`default_nettype wire

// ===== verif/mtv_checker.sv =====
`timescale 1ns / 100ps
// mtv_checker: watches the word and verdict channels of the markup tag validator,
// tracks the parse of each text and checks every verdict in order; uses mtv_pkg
module mtv_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       last_byte,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic       text_valid,
	output int              mismatches,
	output int              verdicts_due,
	output int              verdicts_seen,
	output int              valid_seen,
	output int              words_seen
);

	localparam int STACK_DEPTH = mtv_pkg::STACK_DEPTH_DEF;
	localparam int NAME_MAX    = mtv_pkg::NAME_MAX_LEN_DEF;
	localparam int NAME_W      = mtv_pkg::LETTER_W * NAME_MAX;
	localparam logic [55:0] CDATA_OPENER = {mtv_pkg::CH_LBRK, mtv_pkg::CH_C, mtv_pkg::CH_D,
		mtv_pkg::CH_A, mtv_pkg::CH_T, mtv_pkg::CH_A, mtv_pkg::CH_LBRK};

	typedef enum logic [3:0] {
		PS_START,
		PS_CONTENT,
		PS_LT,
		PS_CD_PREFIX,
		PS_CD_BODY,
		PS_OPEN_NAME,
		PS_CLOSE_NAME,
		PS_DONE,
		PS_ERROR
	} parse_state_t;

	// parse state of the text in flight
	parse_state_t      mode;
	logic [2:0]        cd_idx;
	logic [1:0]        rbrk_run;
	logic [NAME_W-1:0] name_bits;
	logic [3:0]        name_len;
	logic [NAME_W+3:0] tag_stack [STACK_DEPTH];
	int                depth;
	bit                root_opened;
	bit                sticky_err;

	bit expected_verdicts [$];
	bit want;

	function automatic bit is_letter(input logic [7:0] c);
		return c >= mtv_pkg::CH_A && c <= mtv_pkg::CH_Z;
	endfunction

	task automatic clear_parse();
		mode = PS_START;
		cd_idx = '0;
		rbrk_run = '0;
		name_bits = '0;
		name_len = '0;
		depth = 0;
		root_opened = 0;
		sticky_err = 0;
	endtask

	task automatic raise_error();
		sticky_err = 1;
		mode = PS_ERROR;
	endtask

	// append one letter to the name being read, too long is an error
	task automatic take_letter(input logic [7:0] c);
		if (name_len >= NAME_MAX) begin
			raise_error();
		end else begin
			name_bits = {name_bits[NAME_W-mtv_pkg::LETTER_W-1:0],
				5'(c - mtv_pkg::CH_A + 8'd1)};
			name_len = name_len + 4'd1;
		end
	endtask

	// advance the parse by one word, queue a verdict on the last one
	task automatic parse_word(input logic [7:0] c, input logic last);
		case (mode)
			PS_START: begin
				if (c == mtv_pkg::CH_LT) mode = PS_LT;
				else raise_error();
			end
			PS_CONTENT: begin
				if (c == mtv_pkg::CH_LT) mode = PS_LT;
			end
			PS_LT: begin
				if (c == mtv_pkg::CH_BANG) begin
					if (depth == 0) begin
						raise_error();
					end else begin
						cd_idx = '0;
						mode = PS_CD_PREFIX;
					end
				end else if (c == mtv_pkg::CH_SLASH) begin
					name_bits = '0;
					name_len = '0;
					mode = PS_CLOSE_NAME;
				end else if (is_letter(c)) begin
					if (depth == 0 && root_opened) begin
						raise_error();
					end else begin
						name_bits = '0;
						name_len = '0;
						mode = PS_OPEN_NAME;
						take_letter(c);
					end
				end else begin
					raise_error();
				end
			end
			PS_CD_PREFIX: begin
				if (c == CDATA_OPENER[8 * (6 - int'(cd_idx)) +: 8]) begin
					cd_idx = cd_idx + 3'd1;
					if (cd_idx == mtv_pkg::CD_LEN) begin
						rbrk_run = '0;
						mode = PS_CD_BODY;
					end
				end else begin
					raise_error();
				end
			end
			PS_CD_BODY: begin
				if (c == mtv_pkg::CH_RBRK) begin
					if (rbrk_run < 2'd2) rbrk_run = rbrk_run + 2'd1;
				end else if (c == mtv_pkg::CH_GT && rbrk_run == 2'd2) begin
					rbrk_run = '0;
					mode = PS_CONTENT;
				end else begin
					rbrk_run = '0;
				end
			end
			PS_OPEN_NAME: begin
				if (is_letter(c)) begin
					take_letter(c);
				end else if (c == mtv_pkg::CH_GT && name_len != 0) begin
					if (depth >= STACK_DEPTH) begin
						raise_error();
					end else begin
						tag_stack[depth] = {name_len, name_bits};
						depth++;
						root_opened = 1;
						mode = PS_CONTENT;
					end
				end else begin
					raise_error();
				end
			end
			PS_CLOSE_NAME: begin
				if (is_letter(c)) begin
					take_letter(c);
				end else if (c == mtv_pkg::CH_GT && name_len != 0 && depth != 0 &&
						tag_stack[depth-1] == {name_len, name_bits}) begin
					depth--;
					mode = (depth == 0) ? PS_DONE : PS_CONTENT;
				end else begin
					raise_error();
				end
			end
			default: raise_error();
		endcase

		if (last) begin
			expected_verdicts.push_back(!sticky_err && mode == PS_DONE && root_opened &&
				depth == 0);
			clear_parse();
		end
	endtask

	// compare verdicts first, then take the new word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_verdicts.delete();
			mismatches = 0;
			verdicts_due = 0;
			verdicts_seen = 0;
			valid_seen = 0;
			words_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("text_valid: verdict with none expected, actual %0b", text_valid);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_seen++;
					if (want) valid_seen++;
					if (text_valid !== want) begin
						$error("text_valid mismatch: expected %0b, actual %0b", want, text_valid);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				words_seen++;
				parse_word(text_byte, last_byte);
			end
			verdicts_due = expected_verdicts.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// testbench: top of the markup tag validator test; builds well-formed and broken
// texts, drives them with random gaps and stalls; needs mtv_pkg, the block and mtv_checker
module testbench;

	localparam int STACK_DEPTH  = mtv_pkg::STACK_DEPTH_DEF;
	localparam int NAME_MAX     = mtv_pkg::NAME_MAX_LEN_DEF;
	localparam int RANDOM_WORDS = 1300;
	localparam int MIN_TEXTS    = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int FLAW_KINDS   = 10;

	typedef struct packed {
		logic [3:0]                len;
		logic [NAME_MAX:0][7:0]    ch;
	} tag_name_t;

	typedef enum int {
		FL_REPLACE,
		FL_TRUNCATE,
		FL_TRAILER,
		FL_STRAY_LT,
		FL_TOP_CDATA,
		FL_SECOND_ROOT,
		FL_EMPTY_NAME,
		FL_EARLY_CLOSE,
		FL_WRONG_CLOSE,
		FL_BAD_PREFIX
	} flaw_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] text_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic       text_valid;

	int mismatches, verdicts_due, verdicts_seen, valid_seen, words_seen;
	int words_sent, texts_sent;
	int cycles = 0;
	bit hold_req, quiet, idle_on, overflow_sent;
	logic [7:0] text_q [$];

	markup_tag_validator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.text_valid (text_valid)
	);

	mtv_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.text_valid    (text_valid),
		.mismatches    (mismatches),
		.verdicts_due  (verdicts_due),
		.verdicts_seen (verdicts_seen),
		.valid_seen    (valid_seen),
		.words_seen    (words_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d verdicts outstanding", verdicts_due);
			$display("simulation failed");
			$finish;
		end
	end

	// bytes the parser reacts to, plus anything at all
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = mtv_pkg::CH_LT;
			1: b = mtv_pkg::CH_GT;
			2: b = mtv_pkg::CH_SLASH;
			3: b = mtv_pkg::CH_BANG;
			4: b = mtv_pkg::CH_LBRK;
			5: b = mtv_pkg::CH_RBRK;
			6: b = mtv_pkg::CH_A + 8'($urandom_range(0, 25));
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	// any content byte but an angle bracket opener
	function automatic logic [7:0] content_byte();
		logic [7:0] b;
		b = ($urandom_range(0, 3) == 0) ? mtv_pkg::CH_RBRK : 8'($urandom_range(0, 255));
		if (b == mtv_pkg::CH_LT) b = mtv_pkg::CH_GT;
		return b;
	endfunction

	// short names from a small alphabet make near misses likely
	function automatic tag_name_t rand_name(input bit allow_long);
		tag_name_t n;
		int k;
		n = '0;
		k = $urandom_range(0, 99);
		if (allow_long && k < 6) n.len = 4'(NAME_MAX + 1);
		else if (k < 16) n.len = 4'(NAME_MAX);
		else n.len = 4'($urandom_range(1, 3));
		for (int i = 0; i < n.len; i++)
			n.ch[i] = (k % 2) ? mtv_pkg::CH_A + 8'($urandom_range(0, 1)) :
				mtv_pkg::CH_A + 8'($urandom_range(0, 25));
		return n;
	endfunction

	task automatic append_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task automatic insert_str(input int idx, input string s);
		for (int i = s.len() - 1; i >= 0; i--) text_q.insert(idx, s[i]);
	endtask

	task automatic emit_tag(input tag_name_t n, input bit closing);
		text_q.push_back(mtv_pkg::CH_LT);
		if (closing) text_q.push_back(mtv_pkg::CH_SLASH);
		for (int i = 0; i < n.len; i++) text_q.push_back(n.ch[i]);
		text_q.push_back(mtv_pkg::CH_GT);
	endtask

	// cdata section with a body that never ends it early
	task automatic add_cdata();
		int run;
		logic [7:0] b;
		run = 0;
		append_str("<![CDATA[");
		repeat ($urandom_range(0, 6)) begin
			b = ($urandom_range(0, 1) == 0) ? mtv_pkg::CH_RBRK : pick_byte();
			if (b == mtv_pkg::CH_GT && run >= 2) b = mtv_pkg::CH_A;
			run = (b == mtv_pkg::CH_RBRK) ? ((run < 2) ? run + 1 : 2) : 0;
			text_q.push_back(b);
		end
		append_str("]]>");
	endtask

	// "<![CDATA[" up to place p, whose byte is swapped for another
	task automatic insert_bad_prefix(input int idx, input int p);
		string opener;
		logic [7:0] b;
		opener = "<![CDATA[";
		b = pick_byte();
		if (b == opener[p]) b = b ^ 8'h01;
		text_q.insert(idx, b);
		for (int i = p - 1; i >= 0; i--) text_q.insert(idx, opener[i]);
	endtask

	// one root element with nested tags, content and cdata; optionally broken once
	task automatic build_doc(input bit flawed);
		tag_name_t open_names [$];
		tag_name_t nm;
		int limit, close_at, k, keep, p;
		logic [7:0] b;
		text_q.delete();
		limit = $urandom_range(4, 30);
		close_at = 0;
		nm = rand_name(flawed);
		emit_tag(nm, 0);
		open_names.push_back(nm);
		while (open_names.size() != 0) begin
			k = $urandom_range(0, 99);
			if (text_q.size() >= limit || k < 22) begin
				if (open_names.size() == 1) close_at = text_q.size();
				nm = open_names.pop_back();
				emit_tag(nm, 1);
			end else if (k < 45 && open_names.size() < 6) begin
				nm = rand_name(flawed);
				emit_tag(nm, 0);
				open_names.push_back(nm);
			end else if (k < 62) begin
				add_cdata();
			end else begin
				repeat ($urandom_range(1, 3)) text_q.push_back(content_byte());
			end
		end
		if (flawed) begin
			case (flaw_t'($urandom_range(0, FLAW_KINDS - 1)))
				FL_REPLACE: text_q[$urandom_range(0, text_q.size() - 1)] = pick_byte();
				FL_TRUNCATE: begin
					keep = $urandom_range(1, text_q.size() - 1);
					while (text_q.size() > keep) b = text_q.pop_back();
				end
				FL_TRAILER: repeat ($urandom_range(1, 2)) text_q.push_back(pick_byte());
				FL_STRAY_LT: begin
					text_q.insert(close_at, pick_byte());
					text_q.insert(close_at, mtv_pkg::CH_LT);
				end
				FL_TOP_CDATA: insert_str(0, "<![CDATA[x]]>");
				FL_SECOND_ROOT: append_str("<B></B>");
				FL_EMPTY_NAME: begin
					if ($urandom_range(0, 1) == 0) insert_str(close_at, "<>");
					else insert_str(close_at, "</>");
				end
				FL_EARLY_CLOSE: insert_str(0, "</A>");
				FL_WRONG_CLOSE: begin
					b = text_q[close_at + 2];
					if ($urandom_range(0, 1) == 0)
						text_q[close_at + 2] = (b == mtv_pkg::CH_Z) ? mtv_pkg::CH_A : b + 8'd1;
					else
						text_q.insert(close_at + 2, mtv_pkg::CH_A + 8'($urandom_range(0, 1)));
				end
				default: begin
					// cdata opener cut short by one wrong byte
					p = $urandom_range(2, 8);
					insert_bad_prefix(close_at, p);
				end
			endcase
		end
	endtask

	task automatic build_noise(input int max_len);
		text_q.delete();
		repeat ($urandom_range(1, max_len)) text_q.push_back(pick_byte());
	endtask

	// one word at a time, each held until the block takes it
	task automatic send_text();
		logic took;
		for (int i = 0; i < text_q.size(); i++) begin
			if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			in_valid <= 1'b1;
			text_byte <= text_q[i];
			last_byte <= (i == text_q.size() - 1);
			do begin
				@(negedge clk);
				took = in_ready;
				@(posedge clk);
			end while (!took);
			words_sent++;
		end
		texts_sent++;
	endtask

	// receiver: one long hold-off on request, random stall bursts otherwise
	initial begin
		bit hold_done, stall_on;
		hold_done = 0;
		stall_on = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end else if (!quiet && stall_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
			if ($urandom_range(0, 63) == 0) stall_on = !stall_on;
		end
	end

	// sender
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		last_byte = 1'b0;
		hold_req = 0;
		quiet = 0;
		idle_on = 0;
		overflow_sent = 0;
		words_sent = 0;
		texts_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes outside an element, smallest valid text,
		// zero and all-ones bytes and a stray cdata end as content, empty name
		text_q = '{8'h00};
		send_text();
		text_q = '{8'hFF};
		send_text();
		text_q.delete();
		append_str("<Z></Z>");
		send_text();
		text_q.delete();
		append_str("<A>");
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		append_str("]]></A>");
		send_text();
		text_q.delete();
		append_str("<>");
		send_text();

		// receiver holds off while short texts keep coming, so the block backs up
		hold_req = 1;
		repeat (24) begin
			build_noise(2);
			send_text();
		end
		hold_req = 0;

		// random texts: noise, well-formed and flawed documents
		while (words_sent < RANDOM_WORDS || texts_sent < MIN_TEXTS) begin
			quiet = (words_sent >= RANDOM_WORDS - 200 && texts_sent >= MIN_TEXTS - 15);
			idle_on = !quiet && ($urandom_range(0, 1) == 1);
			if (!overflow_sent && texts_sent >= 34) begin
				// one more open tag than the stack holds
				text_q.delete();
				repeat (STACK_DEPTH + 1) append_str("<A>");
				append_str("</A>");
				overflow_sent = 1;
			end else if ($urandom_range(0, 9) == 0) begin
				build_noise(8);
			end else begin
				build_doc($urandom_range(0, 99) < 45);
			end
			send_text();
		end

		// drain
		in_valid <= 1'b0;
		last_byte <= 1'b0;
		while (verdicts_due != 0) @(negedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d words in %0d texts, stack overflow and long hold-off included",
			words_sent, texts_sent);
		$display("checked %0d verdicts, %0d valid and %0d invalid",
			verdicts_seen, valid_seen, verdicts_seen - valid_seen);
		if (mismatches == 0 && verdicts_due == 0 && words_seen == words_sent) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
